@@ rtl/core/segi_pkg.sv @@
// ----------------------------------------------------------------------------
// segi_pkg
// Shared types for the segment intersection block: the payload structs of the
// request and response channels and the back-end sequencer states.
// ----------------------------------------------------------------------------
package segi_pkg;

   typedef struct packed {
      logic signed [15:0] first_start_x;
      logic signed [15:0] first_start_y;
      logic signed [15:0] first_end_x;
      logic signed [15:0] first_end_y;
      logic signed [15:0] second_start_x;
      logic signed [15:0] second_start_y;
      logic signed [15:0] second_end_x;
      logic signed [15:0] second_end_y;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               is_empty;
      logic               last_point;
   } rsp_data_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EMIT,
      BK_MUL,
      BK_NUM,
      BK_DIVS,
      BK_DIV
   } bk_state_type;

endpackage

@@ rtl/core/segi_fifo.sv @@
// ----------------------------------------------------------------------------
// segi_fifo
// Four-entry queue of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module segi_fifo import segi_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] mem_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   assign full       = (count_ff == 3'd4);
   assign head_valid = (count_ff != 3'd0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/segi_front.sv @@
// ----------------------------------------------------------------------------
// segi_front
// Accepts transactions, forms the cross and dot products in a two-stage
// pipeline and classifies each pair: sorted endpoint list, proper crossing
// or empty. The classified entry is pushed into the queue.
// ----------------------------------------------------------------------------
module segi_front import segi_pkg::*; #(
   parameter int CW = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         push,
   output logic [1+2+4*CW+2*(2*CW+1)+4*(CW+1)+2*(CW+1)+1-1:0] entry,
   input  logic         full
);

   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int XW   = PW + 1;
   localparam int CCW  = 2 * CW + 1;
   localparam int DENW = 2 * DW + 1;

   // Points: index 0 = A, 1 = B, 2 = C, 3 = D.
   logic signed [CW-1:0] s1_x_ff [4];
   logic signed [CW-1:0] s1_y_ff [4];
   logic                 s1_valid_ff;
   logic signed [CW-1:0] s2_x_ff [4];
   logic signed [CW-1:0] s2_y_ff [4];
   logic                 s2_valid_ff;

   logic signed [PW-1:0]   cm1_ff [4];
   logic signed [PW-1:0]   cm2_ff [4];
   logic signed [PW-1:0]   dm1_ff [4];
   logic signed [PW-1:0]   dm2_ff [4];
   logic signed [PW-1:0]   cm1_in [4];
   logic signed [PW-1:0]   cm2_in [4];
   logic signed [PW-1:0]   dm1_in [4];
   logic signed [PW-1:0]   dm2_in [4];
   logic signed [2*CW-1:0] cp_ff [4];
   logic signed [2*CW-1:0] cp_in [4];
   logic signed [PW-1:0]   dp1_ff, dp2_ff, dp1_in, dp2_in;
   logic signed [DW-1:0]   a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [DW-1:0]   a1_in, b1_in, a2_in, b2_in;

   logic s1_move, s2_move;

   assign s2_move   = s2_valid_ff && !full;
   assign s1_move   = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign req_ready = !s1_valid_ff || s1_move;
   assign push      = s2_move;

   // Stage 2 products. Case k tests candidate point P against segment UV.
   for (genvar k = 0; k < 4; k++) begin : g_prod
      localparam int UI = (k < 2) ? 0 : 2;
      localparam int VI = UI + 1;
      localparam int PI = (k + 2) % 4;
      logic signed [DW-1:0] vux, vuy, pux, puy, pvx, pvy;
      assign vux = DW'(s1_x_ff[VI]) - DW'(s1_x_ff[UI]);
      assign vuy = DW'(s1_y_ff[VI]) - DW'(s1_y_ff[UI]);
      assign pux = DW'(s1_x_ff[PI]) - DW'(s1_x_ff[UI]);
      assign puy = DW'(s1_y_ff[PI]) - DW'(s1_y_ff[UI]);
      assign pvx = DW'(s1_x_ff[PI]) - DW'(s1_x_ff[VI]);
      assign pvy = DW'(s1_y_ff[PI]) - DW'(s1_y_ff[VI]);
      assign cm1_in[k] = PW'(vux) * PW'(puy);
      assign cm2_in[k] = PW'(vuy) * PW'(pux);
      assign dm1_in[k] = PW'(pux) * PW'(pvx);
      assign dm2_in[k] = PW'(puy) * PW'(pvy);
   end

   always_comb begin
      a1_in = DW'(s1_y_ff[1]) - DW'(s1_y_ff[0]);
      b1_in = DW'(s1_x_ff[0]) - DW'(s1_x_ff[1]);
      a2_in = DW'(s1_y_ff[3]) - DW'(s1_y_ff[2]);
      b2_in = DW'(s1_x_ff[2]) - DW'(s1_x_ff[3]);
      dp1_in = PW'(a1_in) * PW'(b2_in);
      dp2_in = PW'(a2_in) * PW'(b1_in);
      cp_in[0] = (2*CW)'(s1_y_ff[0]) * (2*CW)'(s1_x_ff[1]);
      cp_in[1] = (2*CW)'(s1_x_ff[0]) * (2*CW)'(s1_y_ff[1]);
      cp_in[2] = (2*CW)'(s1_y_ff[2]) * (2*CW)'(s1_x_ff[3]);
      cp_in[3] = (2*CW)'(s1_x_ff[2]) * (2*CW)'(s1_y_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_x_ff[0] <= CW'(req_data.first_start_x);
         s1_y_ff[0] <= CW'(req_data.first_start_y);
         s1_x_ff[1] <= CW'(req_data.first_end_x);
         s1_y_ff[1] <= CW'(req_data.first_end_y);
         s1_x_ff[2] <= CW'(req_data.second_start_x);
         s1_y_ff[2] <= CW'(req_data.second_start_y);
         s1_x_ff[3] <= CW'(req_data.second_end_x);
         s1_y_ff[3] <= CW'(req_data.second_end_y);
      end
      if (s1_move) begin
         for (int k = 0; k < 4; k++) begin
            s2_x_ff[k] <= s1_x_ff[k];
            s2_y_ff[k] <= s1_y_ff[k];
            cm1_ff[k]  <= cm1_in[k];
            cm2_ff[k]  <= cm2_in[k];
            dm1_ff[k]  <= dm1_in[k];
            dm2_ff[k]  <= dm2_in[k];
            cp_ff[k]   <= cp_in[k];
         end
         dp1_ff <= dp1_in;
         dp2_ff <= dp2_in;
         a1_ff  <= a1_in;
         b1_ff  <= b1_in;
         a2_ff  <= a2_in;
         b2_ff  <= b2_in;
      end
   end

   // Classification of the stage 2 contents.
   logic signed [XW-1:0]   cross_val [4];
   logic signed [XW-1:0]   dot [4];
   logic                   on_seg [4];
   logic                   kept [4];
   logic [1:0]             rank [4];
   logic signed [CW-1:0]   cx [4];
   logic signed [CW-1:0]   cy [4];
   logic [2:0]             nkept;
   logic signed [CW-1:0]   p0x, p0y, p1x, p1y;
   logic signed [CCW-1:0]  c1, c2;
   logic signed [DENW-1:0] den;
   logic                   proper, is_cross;
   logic [1:0]             count;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cross_val[k] = XW'(cm1_ff[k]) - XW'(cm2_ff[k]);
         dot[k]       = XW'(dm1_ff[k]) + XW'(dm2_ff[k]);
         on_seg[k]    = (cross_val[k] == '0) && (dot[k] <= 0);
         // Candidates in order C, D, A, B.
         cx[k] = s2_x_ff[(k + 2) % 4];
         cy[k] = s2_y_ff[(k + 2) % 4];
      end
      // A candidate is kept unless an earlier candidate holds the same point.
      for (int i = 0; i < 4; i++) begin
         kept[i] = on_seg[i];
         for (int j = 0; j < i; j++) begin
            if (on_seg[j] && cx[j] == cx[i] && cy[j] == cy[i]) begin
               kept[i] = 1'b0;
            end
         end
      end
      nkept = '0;
      for (int i = 0; i < 4; i++) begin
         nkept = nkept + {2'b00, kept[i]};
         rank[i] = '0;
         for (int j = 0; j < 4; j++) begin
            if (j != i && kept[j] &&
                ((cx[j] < cx[i]) || (cx[j] == cx[i] && cy[j] < cy[i]))) begin
               rank[i] = rank[i] + 2'd1;
            end
         end
      end
      p0x = '0;
      p0y = '0;
      p1x = '0;
      p1y = '0;
      for (int i = 0; i < 4; i++) begin
         if (kept[i] && rank[i] == 2'd0) begin
            p0x = cx[i];
            p0y = cy[i];
         end
         if (kept[i] && rank[i] == 2'd1) begin
            p1x = cx[i];
            p1y = cy[i];
         end
      end
      c1  = CCW'(cp_ff[0]) - CCW'(cp_ff[1]);
      c2  = CCW'(cp_ff[2]) - CCW'(cp_ff[3]);
      den = DENW'(dp1_ff) - DENW'(dp2_ff);
      proper = (cross_val[0] != '0) && (cross_val[1] != '0) &&
               (cross_val[0][XW-1] != cross_val[1][XW-1]) &&
               (cross_val[2] != '0) && (cross_val[3] != '0) &&
               (cross_val[2][XW-1] != cross_val[3][XW-1]);
      is_cross = (nkept == 3'd0) && proper && (den != '0);
      if (nkept == 3'd0) begin
         count = 2'd0;
      end else if (nkept == 3'd1) begin
         count = 2'd1;
      end else begin
         count = 2'd2;
      end
   end

   assign entry = {is_cross, count, p0x, p0y, p1x, p1y, c1, c2,
                   a1_ff, b1_ff, a2_ff, b2_ff, den};

endmodule

@@ rtl/core/segi_div.sv @@
// ----------------------------------------------------------------------------
// segi_div
// Restoring divider, one quotient bit per cycle. Divides the crossing
// numerator, scaled by the fraction bits, by the determinant and truncates
// toward zero.
// ----------------------------------------------------------------------------
module segi_div import segi_pkg::*; #(
   parameter int CW = 16,
   parameter int FB = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [3*CW+2:0]    num,
   input  logic signed [2*CW+2:0]    den,
   output logic                      done,
   output logic signed [CW+FB:0]     quo
);

   localparam int NW0  = 3 * CW + 3;
   localparam int NW   = NW0 + FB;
   localparam int DENW = 2 * CW + 3;
   localparam int QW   = CW + FB;
   localparam int RW   = 2 * CW + 4;
   localparam int CNTW = $clog2(QW + 1);

   logic            busy_ff, done_ff, neg_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [DENW-1:0] dmag_ff;

   logic [NW0-1:0]  nmag;
   logic [DENW-1:0] dmag;
   logic [NW-1:0]   shifted;
   logic [RW-1:0]   rem_sh;
   logic            ge;

   always_comb begin
      nmag    = num[NW0-1] ? NW0'(-num) : NW0'(num);
      dmag    = den[DENW-1] ? DENW'(-den) : DENW'(den);
      shifted = NW'(nmag) << FB;
      rem_sh  = {rem_ff[RW-2:0], q_ff[QW-1]};
      ge      = rem_sh >= RW'(dmag_ff);
      if (start) begin
         // The quotient fits in QW bits, so the upper part is below the divisor.
         rem_in = RW'(shifted[NW-1:QW]);
         q_in   = shifted[QW-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - RW'(dmag_ff) : rem_sh;
         q_in   = {q_ff[QW-2:0], ge};
      end else begin
         rem_in = rem_ff;
         q_in   = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNTW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         dmag_ff <= dmag;
         neg_ff  <= num[NW0-1] ^ den[DENW-1];
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff});

endmodule

@@ rtl/core/segi_back.sv @@
// ----------------------------------------------------------------------------
// segi_back
// Takes classified entries from the queue and emits result transactions:
// sorted endpoints directly, a proper crossing after the numerator products
// and two parallel divisions.
// ----------------------------------------------------------------------------
module segi_back import segi_pkg::*; #(
   parameter int CW = 16,
   parameter int FB = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  logic [1+2+4*CW+2*(2*CW+1)+4*(CW+1)+2*(CW+1)+1-1:0] q_entry,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int DW   = CW + 1;
   localparam int CCW  = 2 * CW + 1;
   localparam int DENW = 2 * DW + 1;
   localparam int MW   = CCW + DW;
   localparam int NW0  = MW + 1;
   localparam int QW   = CW + FB;
   localparam int SW   = (QW + 1 > 33) ? QW + 1 : 33;
   localparam logic signed [SW-1:0] SAT_HI = SW'(32'sh7FFF_FFFF);
   localparam logic signed [SW-1:0] SAT_LO = SW'(32'sh8000_0000);

   logic                   e_cross;
   logic [1:0]             e_count;
   logic signed [CW-1:0]   e_p0x, e_p0y, e_p1x, e_p1y;
   logic signed [CCW-1:0]  e_c1, e_c2;
   logic signed [DW-1:0]   e_a1, e_b1, e_a2, e_b2;
   logic signed [DENW-1:0] e_den;

   assign {e_cross, e_count, e_p0x, e_p0y, e_p1x, e_p1y, e_c1, e_c2,
           e_a1, e_b1, e_a2, e_b2, e_den} = q_entry;

   bk_state_type state_ff, state_in;

   logic signed [QW:0]     px_ff [2];
   logic signed [QW:0]     py_ff [2];
   logic signed [QW:0]     px_in [2];
   logic signed [QW:0]     py_in [2];
   logic [1:0]             cnt_ff, cnt_in;
   logic                   idx_ff, idx_in;
   logic signed [CCW-1:0]  c1_ff, c2_ff, c1_in, c2_in;
   logic signed [DW-1:0]   a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [DW-1:0]   a1_in, b1_in, a2_in, b2_in;
   logic signed [DENW-1:0] den_ff, den_in;
   logic signed [MW-1:0]   m_ff [4];
   logic signed [MW-1:0]   m_in [4];
   logic signed [NW0-1:0]  numx_ff, numy_ff, numx_in, numy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;

   logic               out_free, emit_last, div_start;
   logic               done_x, done_y;
   logic signed [QW:0] quo_x, quo_y;
   logic signed [SW-1:0] vx, vy;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = (cnt_ff != 2'd2) || idx_ff;
   assign q_pop     = q_valid && ((state_ff == BK_IDLE) ||
                      (state_ff == BK_EMIT && out_free && emit_last));

   segi_div #(.CW(CW), .FB(FB)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (numx_ff),
      .den   (den_ff),
      .done  (done_x),
      .quo   (quo_x)
   );

   segi_div #(.CW(CW), .FB(FB)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (numy_ff),
      .den   (den_ff),
      .done  (done_y),
      .quo   (quo_y)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               state_in = e_cross ? BK_MUL : BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && emit_last) begin
               if (q_pop) begin
                  state_in = e_cross ? BK_MUL : BK_EMIT;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_MUL:  state_in = BK_NUM;
         BK_NUM:  state_in = BK_DIVS;
         BK_DIVS: state_in = BK_DIV;
         BK_DIV: begin
            if (done_x && done_y) begin
               state_in = BK_EMIT;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      px_in        = px_ff;
      py_in        = py_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      a1_in        = a1_ff;
      b1_in        = b1_ff;
      a2_in        = a2_ff;
      b2_in        = b2_ff;
      den_in       = den_ff;
      m_in         = m_ff;
      numx_in      = numx_ff;
      numy_in      = numy_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      vx = SW'(px_ff[idx_ff]);
      vy = SW'(py_ff[idx_ff]);

      if (state_ff == BK_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         if (cnt_ff == 2'd0) begin
            rsp_data_in.point_x  = '0;
            rsp_data_in.point_y  = '0;
            rsp_data_in.is_empty = 1'b1;
         end else begin
            rsp_data_in.point_x = (vx > SAT_HI) ? 32'sh7FFF_FFFF :
                                  (vx < SAT_LO) ? 32'sh8000_0000 : 32'(vx);
            rsp_data_in.point_y = (vy > SAT_HI) ? 32'sh7FFF_FFFF :
                                  (vy < SAT_LO) ? 32'sh8000_0000 : 32'(vy);
            rsp_data_in.is_empty = 1'b0;
         end
         rsp_data_in.last_point = emit_last;
         if (!emit_last) begin
            idx_in = 1'b1;
         end
      end

      if (q_pop) begin
         px_in[0] = (QW + 1)'(e_p0x) <<< FB;
         py_in[0] = (QW + 1)'(e_p0y) <<< FB;
         px_in[1] = (QW + 1)'(e_p1x) <<< FB;
         py_in[1] = (QW + 1)'(e_p1y) <<< FB;
         cnt_in   = e_count;
         idx_in   = 1'b0;
         c1_in    = e_c1;
         c2_in    = e_c2;
         a1_in    = e_a1;
         b1_in    = e_b1;
         a2_in    = e_a2;
         b2_in    = e_b2;
         den_in   = e_den;
      end

      case (state_ff)
         BK_MUL: begin
            m_in[0] = MW'(c2_ff) * MW'(b1_ff);
            m_in[1] = MW'(c1_ff) * MW'(b2_ff);
            m_in[2] = MW'(a2_ff) * MW'(c1_ff);
            m_in[3] = MW'(a1_ff) * MW'(c2_ff);
         end
         BK_NUM: begin
            numx_in = NW0'(m_ff[0]) - NW0'(m_ff[1]);
            numy_in = NW0'(m_ff[2]) - NW0'(m_ff[3]);
         end
         BK_DIVS: div_start = 1'b1;
         BK_DIV: begin
            if (done_x && done_y) begin
               px_in[0] = quo_x;
               py_in[0] = quo_y;
               cnt_in   = 2'd1;
               idx_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      a1_ff       <= a1_in;
      b1_ff       <= b1_in;
      a2_ff       <= a2_in;
      b2_ff       <= b2_in;
      den_ff      <= den_in;
      m_ff        <= m_in;
      numx_ff     <= numx_in;
      numy_ff     <= numy_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/segment_intersection.sv @@
// ----------------------------------------------------------------------------
// segment_intersection
// Common points of two closed integer segments AB and CD.
// ----------------------------------------------------------------------------
// Each request transaction carries the four endpoints. The block answers with
// one or two response transactions holding the common points sorted by x,
// then y, in fixed point with FRAC_BITS fraction bits; last_point marks the
// final one. When the segments do not meet, one transaction with is_empty set
// and zero coordinates is returned.
// The front end takes a request every cycle unless a full queue stalls it,
// into a two-stage product pipeline, and pushes the classified transaction
// into a four-entry queue. Endpoint results leave at one response per cycle
// while rsp_ready is high. A proper crossing goes through two numerator
// stages and a bit-serial divider; the divider sets the rate for such
// transactions.
// Reset empties the pipeline and the queue and drops any pending response.
// A stalled response holds the output register; the queue keeps accepting
// entries until it fills, and once both pipeline stages are also full,
// req_ready falls.
// ----------------------------------------------------------------------------
module segment_intersection import segi_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int CW = COORD_BITS;
   localparam int EW = 1 + 2 + 4 * CW + 2 * (2 * CW + 1) + 4 * (CW + 1) + 2 * (CW + 1) + 1;

   logic          q_push, q_full, q_pop, q_valid;
   logic [EW-1:0] q_in_entry, q_head;

   segi_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (q_push),
      .entry     (q_in_entry),
      .full      (q_full)
   );

   segi_fifo #(.WIDTH(EW)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   segi_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.last_point && rsp_data.point_x == 0 && rsp_data.point_y == 0)
      else $error("empty response not final or not zero");

endmodule
